>>> hdl/rld_pkg.sv
// Package for the run-list decoder: payload structs, result kinds, parser phases
// and field-size limits.
// No dependencies; every other file in hdl/ uses it by scoped names.
package rld_pkg;

  // Largest byte count for the length field or the offset field of one run.
  localparam int unsigned MAX_FIELD_BYTES = 8;
  localparam logic [3:0] MaxFieldBytes = 4'(MAX_FIELD_BYTES);
  localparam logic [3:0] NibbleMask = 4'hF;

  typedef enum logic [1:0] {
    KIND_SEGMENT  = 2'd0,
    KIND_LIST_END = 2'd1,
    KIND_ERROR    = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_LENGTH = 2'd1,
    PH_OFFSET = 2'd2
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } in_item_t;

  typedef struct packed {
    kind_e              kind;
    logic [63:0]        segment_start_vcn;
    logic [63:0]        segment_end_vcn;
    logic signed [63:0] start_cluster;
    logic               list_done;
  } out_item_t;

endpackage

>>> hdl/rld_in_stage.sv
// Input register of the run-list decoder: holds one accepted byte until the
// parser takes it. Depends on rld_pkg.
module rld_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  rld_pkg::in_item_t data_i,
  output logic              item_valid_o,
  output rld_pkg::in_item_t item_o,
  input  logic              take_i
);

  logic              valid_q;
  rld_pkg::in_item_t data_q;

  // A new byte may enter in the same cycle that the held one is taken.
  assign ready_o      = !valid_q || take_i;
  assign item_valid_o = valid_q;
  assign item_o       = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (valid_i && ready_o) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_i;
    end
  end

endmodule

>>> hdl/rld_parser.sv
// Per-byte parser of the run list: decode state, accumulators, running VCN and
// cluster, and the start VCN register. Depends on rld_pkg.
module rld_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [63:0]        cfg_wdata_i,
  input  logic               fire_i,
  input  rld_pkg::in_item_t  item_i,
  output logic               res_valid_o,
  output rld_pkg::out_item_t res_o
);

  rld_pkg::phase_e phase_q, phase_d;
  logic [3:0]  len_left_q, len_left_d;
  logic [3:0]  off_total_q, off_total_d;
  logic [2:0]  pos_q, pos_d;
  logic [63:0] len_acc_q, len_acc_d;
  logic [63:0] off_acc_q, off_acc_d;
  logic [63:0] next_vcn_q, next_vcn_d;
  logic [63:0] cluster_q, cluster_d;
  logic        discard_q, discard_d;
  logic        list_start_q, list_start_d;
  logic [63:0] start_vcn_q;

  logic [63:0] byte_shifted;
  logic [63:0] len_acc_new;
  logic [63:0] off_new;
  logic [63:0] off_ext;
  logic [2:0]  sign_lane;
  logic        sign_bit;
  logic [3:0]  pos_next;
  logic [3:0]  len_nib;
  logic [3:0]  off_nib;
  logic        eob;
  logic        seg_emit;
  logic        err_emit;
  logic        end_emit;
  logic [63:0] seg_end;

  assign eob          = item_i.end_of_buffer;
  assign len_nib      = item_i.data_byte[3:0] & rld_pkg::NibbleMask;
  assign off_nib      = item_i.data_byte[7:4];
  assign pos_next     = {1'b0, pos_q} + 4'd1;
  assign byte_shifted = {56'd0, item_i.data_byte} << {pos_q, 3'b000};
  assign len_acc_new  = len_acc_q | byte_shifted;
  assign off_new      = off_acc_q | byte_shifted;

  // Sign-extend the offset from its byte count; the sign bit is the top bit
  // of the last byte that was received.
  assign sign_lane = 3'(off_total_q - 4'd1);
  assign sign_bit  = off_new[{sign_lane, 3'b111}];

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      off_ext[8*i +: 8] = (4'(i) < off_total_q) ? off_new[8*i +: 8] : {8{sign_bit}};
    end
  end

  // In the length phase the byte being taken completes the length.
  assign seg_end = next_vcn_q +
                   ((phase_q == rld_pkg::PH_LENGTH) ? len_acc_new : len_acc_q);

  always_comb begin
    phase_d      = phase_q;
    len_left_d   = len_left_q;
    off_total_d  = off_total_q;
    pos_d        = pos_q;
    len_acc_d    = len_acc_q;
    off_acc_d    = off_acc_q;
    next_vcn_d   = next_vcn_q;
    cluster_d    = cluster_q;
    discard_d    = discard_q;
    list_start_d = list_start_q;
    seg_emit     = 1'b0;
    err_emit     = 1'b0;
    end_emit     = 1'b0;

    if (fire_i) begin
      if (discard_q) begin
        if (eob) begin
          discard_d    = 1'b0;
          list_start_d = 1'b1;
        end
      end else begin
        case (phase_q)
          rld_pkg::PH_LENGTH: begin
            len_acc_d  = len_acc_new;
            pos_d      = 3'(pos_next);
            len_left_d = len_left_q - 4'd1;
            if (len_left_q == 4'd1) begin
              if (off_total_q == 4'd0) begin
                // A run without offset bytes is sparse.
                cluster_d = '1;
                seg_emit  = 1'b1;
              end else begin
                phase_d = rld_pkg::PH_OFFSET;
                pos_d   = 3'd0;
                err_emit = eob;
              end
            end else begin
              err_emit = eob;
            end
          end
          rld_pkg::PH_OFFSET: begin
            off_acc_d = off_new;
            pos_d     = 3'(pos_next);
            if (pos_next >= off_total_q) begin
              // A negative previous cluster means no base yet: take the raw offset.
              cluster_d = cluster_q[63] ? off_ext : cluster_q + off_ext;
              seg_emit  = 1'b1;
            end else begin
              err_emit = eob;
            end
          end
          default: begin
            if (list_start_q) begin
              next_vcn_d   = start_vcn_q[63] ? 64'd0 : start_vcn_q;
              cluster_d    = '1;
              list_start_d = 1'b0;
            end
            if (item_i.data_byte == 8'd0) begin
              end_emit = 1'b1;
            end else if (len_nib == 4'd0 || len_nib > rld_pkg::MaxFieldBytes ||
                         off_nib > rld_pkg::MaxFieldBytes || eob) begin
              err_emit = 1'b1;
            end else begin
              len_left_d  = len_nib;
              off_total_d = off_nib;
              pos_d       = 3'd0;
              len_acc_d   = '0;
              off_acc_d   = '0;
              phase_d     = rld_pkg::PH_LENGTH;
            end
          end
        endcase

        if (seg_emit || err_emit || end_emit) begin
          phase_d = rld_pkg::PH_HEADER;
          if (eob) begin
            list_start_d = 1'b1;
            discard_d    = 1'b0;
          end else begin
            discard_d = !seg_emit;
          end
        end
        if (seg_emit) begin
          next_vcn_d = seg_end;
        end
      end
    end
  end

  always_comb begin
    res_valid_o             = seg_emit || err_emit || end_emit;
    res_o.kind              = rld_pkg::KIND_SEGMENT;
    res_o.segment_start_vcn = '0;
    res_o.segment_end_vcn   = '0;
    res_o.start_cluster     = '0;
    res_o.list_done         = eob;
    if (seg_emit) begin
      res_o.segment_start_vcn = next_vcn_q;
      res_o.segment_end_vcn   = seg_end;
      res_o.start_cluster     = cluster_d;
    end else if (end_emit) begin
      res_o.kind = rld_pkg::KIND_LIST_END;
    end else if (err_emit) begin
      res_o.kind = rld_pkg::KIND_ERROR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= rld_pkg::PH_HEADER;
      len_left_q   <= '0;
      off_total_q  <= '0;
      pos_q        <= '0;
      len_acc_q    <= '0;
      off_acc_q    <= '0;
      next_vcn_q   <= '0;
      cluster_q    <= '1;
      discard_q    <= 1'b0;
      list_start_q <= 1'b1;
      start_vcn_q  <= '0;
    end else begin
      phase_q      <= phase_d;
      len_left_q   <= len_left_d;
      off_total_q  <= off_total_d;
      pos_q        <= pos_d;
      len_acc_q    <= len_acc_d;
      off_acc_q    <= off_acc_d;
      next_vcn_q   <= next_vcn_d;
      cluster_q    <= cluster_d;
      discard_q    <= discard_d;
      list_start_q <= list_start_d;
      if (cfg_we_i) begin
        start_vcn_q <= cfg_wdata_i;
      end
    end
  end

endmodule

>>> hdl/rld_out_stage.sv
// Result register of the run-list decoder: holds one result until the
// consumer takes it. Depends on rld_pkg.
module rld_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  logic               res_valid_i,
  input  rld_pkg::out_item_t res_i,
  output logic               can_load_o,
  output logic               valid_o,
  input  logic               ready_i,
  output rld_pkg::out_item_t data_o
);

  logic               valid_q;
  rld_pkg::out_item_t data_q;

  // The register may be reloaded in the cycle its current result transfers.
  assign can_load_o = !valid_q || ready_i;
  assign valid_o    = valid_q;
  assign data_o     = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= res_valid_i;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && res_valid_i) begin
      data_q <= res_i;
    end
  end

endmodule

>>> hdl/data_run_list_decoder.sv
// Run-list decoder: takes one run-list byte per transfer and returns at most one
// result per byte (segment, list end or error). A byte is accepted every cycle
// while results are taken. Its result passes two registers: the byte sits in the
// input register, passes the parser logic and is caught by the result register,
// from which it transfers. A result that waits stalls the input. Bytes that yield
// no result still pass through the parser in order.
// start_vcn is written through cfg_we_i/cfg_wdata_i; the user must write it only
// while the block is idle, which the block itself does not enforce.
// Depends on rld_pkg, rld_in_stage, rld_parser and rld_out_stage.
module data_run_list_decoder (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  rld_pkg::in_item_t  data_i,
  output logic               valid_o,
  input  logic               ready_i,
  output rld_pkg::out_item_t data_o,
  input  logic               cfg_we_i,
  input  logic [63:0]        cfg_wdata_i
);

  logic               item_valid;
  rld_pkg::in_item_t  item;
  logic               fire;
  logic               can_load;
  logic               res_valid;
  rld_pkg::out_item_t res;

  assign fire = item_valid && can_load;

  rld_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (valid_i),
    .ready_o      (ready_o),
    .data_i       (data_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .take_i       (fire)
  );

  rld_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (fire),
    .item_i      (item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  rld_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire),
    .res_valid_i (res_valid),
    .res_i       (res),
    .can_load_o  (can_load),
    .valid_o     (valid_o),
    .ready_i     (ready_i),
    .data_o      (data_o)
  );

endmodule

>>> test/tb_data_run_list_decoder.sv
`timescale 1ns / 1ps
// Testbench for data_run_list_decoder: feeds run-list byte streams and checks every
// result against a scoreboard that tracks the decoder state byte by byte.
// Depends on rld_pkg and the RTL in hdl/.
module tb_data_run_list_decoder;

  localparam int unsigned RunLimitNs = 5_000_000;
  localparam int unsigned SettleCycles = 6;
  localparam int unsigned PhaseBytes = 500;

  class run_list_scoreboard;
    rld_pkg::out_item_t expected_q[$];
    logic [63:0] start_vcn_reg;
    rld_pkg::phase_e parse_phase;
    int unsigned len_remaining, off_count, field_pos;
    logic [63:0] len_acc, off_acc, vcn_next, cluster_now;
    bit skip_to_eob, fresh_list;
    int unsigned mismatches, bytes_parsed, n_segments, n_list_ends, n_bad_lists;

    function new();
      start_vcn_reg = '0;
      parse_phase = rld_pkg::PH_HEADER;
      len_remaining = 0;
      off_count = 0;
      field_pos = 0;
      len_acc = '0;
      off_acc = '0;
      vcn_next = '0;
      cluster_now = '1;
      skip_to_eob = 1'b0;
      fresh_list = 1'b1;
      mismatches = 0;
      bytes_parsed = 0;
      n_segments = 0;
      n_list_ends = 0;
      n_bad_lists = 0;
    endfunction

    function void set_start_vcn(logic [63:0] v);
      start_vcn_reg = v;
    endfunction

    function int unsigned outstanding();
      return expected_q.size();
    endfunction

    // A list that stops before the buffer end makes the rest of the buffer ignored.
    function void close_list(logic eob, bit skip_rest);
      parse_phase = rld_pkg::PH_HEADER;
      if (eob) begin
        fresh_list = 1'b1;
        skip_to_eob = 1'b0;
      end else begin
        skip_to_eob = skip_rest;
      end
    endfunction

    function void push_segment(logic eob);
      rld_pkg::out_item_t r;
      r.kind = rld_pkg::KIND_SEGMENT;
      r.segment_start_vcn = vcn_next;
      r.segment_end_vcn = vcn_next + len_acc;
      r.start_cluster = cluster_now;
      r.list_done = eob;
      vcn_next = r.segment_end_vcn;
      expected_q.push_back(r);
      n_segments++;
      close_list(eob, 1'b0);
    endfunction

    function void push_list_stop(rld_pkg::kind_e k, logic eob);
      rld_pkg::out_item_t r;
      r = '0;
      r.kind = k;
      r.list_done = eob;
      expected_q.push_back(r);
      if (k == rld_pkg::KIND_LIST_END) n_list_ends++;
      else n_bad_lists++;
      close_list(eob, 1'b1);
    endfunction

    function void note_byte(rld_pkg::in_item_t it);
      logic [7:0] b;
      logic eob;
      logic [63:0] ofs;
      b = it.data_byte;
      eob = it.end_of_buffer;
      if (skip_to_eob) begin
        if (eob) begin
          skip_to_eob = 1'b0;
          fresh_list = 1'b1;
        end
        return;
      end
      bytes_parsed++;
      case (parse_phase)
        rld_pkg::PH_LENGTH: begin
          len_acc |= 64'(b) << (8 * (field_pos % 8));
          field_pos++;
          len_remaining--;
          if (len_remaining == 0) begin
            if (off_count == 0) begin
              // A run without offset bytes is sparse.
              cluster_now = '1;
              push_segment(eob);
              return;
            end
            parse_phase = rld_pkg::PH_OFFSET;
            field_pos = 0;
          end
          if (eob) push_list_stop(rld_pkg::KIND_ERROR, eob);
        end
        rld_pkg::PH_OFFSET: begin
          off_acc |= 64'(b) << (8 * (field_pos % 8));
          field_pos++;
          if (field_pos >= off_count) begin
            ofs = off_acc;
            if (off_count < 8 && ofs[8 * off_count - 1]) ofs |= ~64'd0 << (8 * off_count);
            // While the running cluster is negative the offset is taken as is.
            if (cluster_now[63]) cluster_now = ofs;
            else cluster_now += ofs;
            push_segment(eob);
          end else if (eob) begin
            push_list_stop(rld_pkg::KIND_ERROR, eob);
          end
        end
        default: begin
          if (fresh_list) begin
            vcn_next = start_vcn_reg[63] ? 64'd0 : start_vcn_reg;
            cluster_now = '1;
            fresh_list = 1'b0;
          end
          if (b == 8'd0) begin
            push_list_stop(rld_pkg::KIND_LIST_END, eob);
          end else if (b[3:0] == 4'd0 || b[3:0] > rld_pkg::MaxFieldBytes
                       || b[7:4] > rld_pkg::MaxFieldBytes || eob) begin
            push_list_stop(rld_pkg::KIND_ERROR, eob);
          end else begin
            len_remaining = b[3:0];
            off_count = b[7:4];
            field_pos = 0;
            len_acc = '0;
            off_acc = '0;
            parse_phase = rld_pkg::PH_LENGTH;
          end
        end
      endcase
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= 100) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_result(rld_pkg::out_item_t got);
      rld_pkg::out_item_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result with no pending expectation, kind %0d", got.kind));
        return;
      end
      want = expected_q.pop_front();
      if (got.kind !== want.kind)
        report($sformatf("kind %0d, expected %0d", got.kind, want.kind));
      if (got.segment_start_vcn !== want.segment_start_vcn)
        report($sformatf("segment_start_vcn %h, expected %h",
                         got.segment_start_vcn, want.segment_start_vcn));
      if (got.segment_end_vcn !== want.segment_end_vcn)
        report($sformatf("segment_end_vcn %h, expected %h",
                         got.segment_end_vcn, want.segment_end_vcn));
      if (got.start_cluster !== want.start_cluster)
        report($sformatf("start_cluster %h, expected %h",
                         got.start_cluster, want.start_cluster));
      if (got.list_done !== want.list_done)
        report($sformatf("list_done %b, expected %b", got.list_done, want.list_done));
    endtask
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               valid_i;
  logic               ready_o;
  rld_pkg::in_item_t  data_i;
  logic               valid_o;
  logic               ready_i;
  rld_pkg::out_item_t data_o;
  logic               cfg_we_i;
  logic [63:0]        cfg_wdata_i;

  run_list_scoreboard sb = new();
  int unsigned send_pct = 0;
  int unsigned recv_pct = 0;

  data_run_list_decoder uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (valid_i),
    .ready_o    (ready_o),
    .data_i     (data_i),
    .valid_o    (valid_o),
    .ready_i    (ready_i),
    .data_o     (data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #(RunLimitNs);
    $display("status: fail");
    $finish;
  end

  // Result side: check each transfer, then pick the next ready value.
  initial begin
    ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && valid_o === 1'b1 && ready_i) sb.check_result(data_o);
      ready_i <= ($urandom_range(99) >= recv_pct);
    end
  end

  task automatic send_byte(logic [7:0] b, logic eob);
    rld_pkg::in_item_t it;
    it.data_byte = b;
    it.end_of_buffer = eob;
    while ($urandom_range(99) < send_pct) begin
      valid_i <= 1'b0;
      @(posedge clk_i);
    end
    valid_i <= 1'b1;
    data_i <= it;
    do @(posedge clk_i); while (ready_o !== 1'b1);
    sb.note_byte(it);
  endtask

  task automatic write_start_vcn(logic [63:0] v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    sb.set_start_vcn(v);
    cfg_we_i <= 1'b0;
  endtask

  // Holds the stream until every result is back, plus time for bytes still in flight.
  task automatic hold_until_drained();
    valid_i <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic logic [7:0] field_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic send_run(bit eob_at_end);
    int unsigned ll, ol;
    ll = ($urandom_range(7) == 0) ? $urandom_range(4, 8) : $urandom_range(1, 3);
    ol = ($urandom_range(3) == 0) ? $urandom_range(0, 8) : $urandom_range(0, 3);
    send_byte({4'(ol), 4'(ll)}, 1'b0);
    for (int i = 1; i <= ll + ol; i++) send_byte(field_byte(), eob_at_end && i == ll + ol);
  endtask

  task automatic send_random_list();
    int unsigned runs, ending;
    runs = $urandom_range(1, 5);
    ending = $urandom_range(3);
    for (int r = 0; r < runs; r++) send_run(ending == 0 && r == runs - 1);
    case (ending)
      1: send_byte(8'h00, 1'b1);
      2: begin
        send_byte(8'h00, 1'b0);
        repeat ($urandom_range(0, 3)) send_byte(8'($urandom), 1'b0);
        send_byte(8'($urandom), 1'b1);
      end
      // Otherwise the list either ended with its last run or runs on into the next one.
      default: ;
    endcase
  endtask

  task automatic send_noise();
    logic [7:0] hdr;
    int unsigned ll, ol, cut;
    case ($urandom_range(2))
      0: begin
        do hdr = 8'($urandom);
        while (!(hdr != 8'd0 && (hdr[3:0] == 4'd0 || hdr[3:0] > rld_pkg::MaxFieldBytes
                                 || hdr[7:4] > rld_pkg::MaxFieldBytes)));
        send_byte(hdr, $urandom_range(3) == 0);
      end
      1: begin
        // The buffer ends partway through a run.
        ll = $urandom_range(1, 8);
        ol = $urandom_range(0, 8);
        cut = $urandom_range(0, ll + ol - 1);
        send_byte({4'(ol), 4'(ll)}, cut == 0);
        for (int i = 1; i <= cut; i++) send_byte(field_byte(), i == cut);
      end
      default: repeat ($urandom_range(1, 6)) send_byte(8'($urandom), $urandom_range(7) == 0);
    endcase
    // Any byte that ends the buffer brings the parser back to a fresh list.
    send_byte(8'($urandom), 1'b1);
  endtask

  task automatic run_random(int unsigned count);
    int unsigned stop_at;
    stop_at = sb.bytes_parsed + count;
    while (sb.bytes_parsed < stop_at) begin
      if ($urandom_range(9) < 8) send_random_list();
      else send_noise();
    end
  endtask

  initial begin
    rst_ni <= 1'b0;
    valid_i <= 1'b0;
    data_i <= '0;
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_pct = 14;
    recv_pct = 60;
    write_start_vcn(64'h7FFF_FFFF_FFFF_FFF0);
    // Sparse run of 255 clusters.
    send_byte(8'h01, 1'b0);
    send_byte(8'hFF, 1'b0);
    // Negative one-byte offset after a sparse run is taken as is.
    send_byte(8'h11, 1'b0);
    send_byte(8'h10, 1'b0);
    send_byte(8'h80, 1'b0);
    // Two-byte positive offset, then a step back by one.
    send_byte(8'h21, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'h12, 1'b0);
    send_byte(8'h11, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'hFF, 1'b0);
    // End marker before the buffer end; the rest of the buffer is skipped.
    send_byte(8'h00, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b1);
    // Length nibble out of range, then the skipped buffer end.
    send_byte(8'h09, 1'b0);
    send_byte(8'h00, 1'b1);
    // A good header on the last byte, then truncation inside the length field.
    send_byte(8'h11, 1'b1);
    send_byte(8'h12, 1'b0);
    send_byte(8'h01, 1'b1);
    // Zero length nibble and offset nibble out of range at a buffer end.
    send_byte(8'h90, 1'b1);
    // Segment that closes the buffer, then an end marker that closes it too.
    send_byte(8'h01, 1'b0);
    send_byte(8'h05, 1'b1);
    send_byte(8'h00, 1'b1);
    hold_until_drained();

    write_start_vcn(64'h8000_0000_0000_0000);
    run_random(PhaseBytes / 2);
    hold_until_drained();
    write_start_vcn('1);
    run_random(PhaseBytes / 2);
    hold_until_drained();

    send_pct = 60;
    recv_pct = 14;
    write_start_vcn(64'h7FFF_FFFF_FFFF_FFFF);
    run_random(PhaseBytes);
    hold_until_drained();

    send_pct = 0;
    recv_pct = 0;
    write_start_vcn({$urandom, $urandom});
    run_random(PhaseBytes);
    hold_until_drained();

    $display("Parsed %0d bytes under three stall profiles and five start_vcn values:",
             sb.bytes_parsed);
    $display("%0d segments, %0d list ends and %0d malformed or truncated lists checked.",
             sb.n_segments, sb.n_list_ends, sb.n_bad_lists);
    if (sb.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/rld_pkg.sv
hdl/rld_in_stage.sv
hdl/rld_parser.sv
hdl/rld_out_stage.sv
hdl/data_run_list_decoder.sv
test/tb_data_run_list_decoder.sv
